### design/text_terminal_cursor_engine_assert.svh
// Assertion macros for the text terminal cursor engine.
// Used by the top level; expects clk and rst in scope.
`ifndef TEXT_TERMINAL_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_TERMINAL_CURSOR_ENGINE_ASSERT_SVH

// same-cycle implication
`define TTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ttc_pkg.sv
// Shared constants, types and address helpers for the text terminal engine.
// No dependencies.
package ttc_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int DEPTH   = ROWS * COLUMNS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ROW_W:0]    ROWS_X    = (ROW_W + 1)'(ROWS);

  localparam logic [7:0]  CH_BACKSPACE = 8'h08;
  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  COLOR_RESET  = 8'h07;
  localparam logic [15:0] RESET_CELL   = {COLOR_RESET, CH_SPACE};

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR
  } state_t;

  // logical row to physical row of the ring
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] org,
                                                input logic [ROW_W-1:0] lrow);
    logic [ROW_W:0] s;
    s = {1'b0, org} + {1'b0, lrow};
    if (s >= ROWS_X) begin
      s = s - ROWS_X;
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    return a;
  endfunction

endpackage

### design/ttc_in_if.sv
// Input channel of the text terminal engine: one put or read item.
// Depends on ttc_pkg for field widths.
interface ttc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [7:0]               char_code;
  logic [ttc_pkg::ROW_W-1:0] read_row;
  logic [ttc_pkg::COL_W-1:0] read_col;

  modport source (output valid, mode, char_code, read_row, read_col, input ready);
  modport sink   (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

### design/ttc_out_if.sv
// Output channel of the text terminal engine: one result item.
// Depends on ttc_pkg for field widths.
interface ttc_out_if;
  logic                     valid;
  logic                     ready;
  logic [7:0]               cell_char;
  logic [7:0]               cell_color;
  logic [ttc_pkg::ROW_W-1:0] cursor_row;
  logic [ttc_pkg::COL_W-1:0] cursor_col;
  logic                     scrolled;

  modport source (output valid, cell_char, cell_color, cursor_row, cursor_col, scrolled,
                  input ready);
  modport sink   (input valid, cell_char, cell_color, cursor_row, cursor_col, scrolled,
                  output ready);
endinterface

### design/text_terminal_cursor_engine.sv
// Top level of the text terminal engine: screen memory, cursor, ring origin.
// Depends on ttc_pkg, ttc_in_if, ttc_out_if and the assertion macro header.
//
//  channel      | dir | handshake            | payload
//  req          | in  | valid/ready          | mode, char_code, read_row, read_col
//  res          | out | valid/ready          | cell_char, cell_color, cursor_row/col, scrolled
//  color_we/... | in  | write enable, 1 reg  | text_color
//
// Put item: single memory write. Read item: goes through the registered read port.
// A put that scrolls then clears the new bottom row, one cell a cycle.
// After reset a clearing pass fills all ROWS*COLUMNS cells; req.ready stays low.
// One item in flight; a new item is taken while the result register empties.
`include "text_terminal_cursor_engine_assert.svh"

module text_terminal_cursor_engine (
  input  logic                 clk,
  input  logic                 rst,
  ttc_in_if.sink               req,
  ttc_out_if.source            res,
  input  logic                 color_we,
  input  logic [7:0]           color_wdata
);

  ttc_pkg::state_t state, state_next;

  logic [15:0] mem [ttc_pkg::DEPTH];
  logic [15:0] mem_rdata;
  logic        mem_we;
  logic [ttc_pkg::ADDR_W-1:0] mem_waddr;
  logic [ttc_pkg::ADDR_W-1:0] mem_raddr;
  logic [15:0] mem_wdata;

  logic [ttc_pkg::ADDR_W-1:0] init_cnt;
  logic [ttc_pkg::COL_W-1:0]  clear_count;
  logic [ttc_pkg::ADDR_W-1:0] clr_base, clr_base_next;
  logic [ttc_pkg::ROW_W-1:0]  origin_row, origin_row_next;
  logic [ttc_pkg::ROW_W-1:0]  cur_row, cur_row_next;
  logic [ttc_pkg::COL_W-1:0]  cur_col, cur_col_next;
  logic [7:0]                 text_color;
  logic                       rd_ok;

  logic                       out_valid;
  logic [7:0]                 o_char, o_color;
  logic [ttc_pkg::ROW_W-1:0]  o_row;
  logic [ttc_pkg::COL_W-1:0]  o_col;
  logic                       o_scr;

  logic accept, is_read, put_scroll, put_done, out_load;
  logic [7:0] o_char_next, o_color_next;

  assign accept  = req.valid && req.ready;
  assign is_read = req.mode;
  assign req.ready = (state == ttc_pkg::ST_IDLE) && (!out_valid || res.ready);

  // put item decode: cursor update and the cell it writes
  logic                       put_we, row_adv;
  logic [ttc_pkg::ROW_W-1:0]  put_row;
  logic [ttc_pkg::COL_W-1:0]  put_col;
  logic [7:0]                 put_ch;

  always_comb begin
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    origin_row_next = origin_row;
    clr_base_next   = clr_base;
    put_we  = 1'b0;
    row_adv = 1'b0;
    put_row = cur_row;
    put_col = cur_col;
    put_ch  = req.char_code;
    put_scroll = 1'b0;
    if (req.char_code == ttc_pkg::CH_NEWLINE) begin
      cur_col_next = '0;
      row_adv = 1'b1;
    end else if (req.char_code == ttc_pkg::CH_BACKSPACE) begin
      if (cur_col != '0 || cur_row != '0) begin
        put_we = 1'b1;
        put_ch = ttc_pkg::CH_SPACE;
        if (cur_col != '0) begin
          cur_col_next = cur_col - 1'b1;
        end else begin
          cur_col_next = ttc_pkg::LAST_COL;
          cur_row_next = cur_row - 1'b1;
        end
        put_row = cur_row_next;
        put_col = cur_col_next;
      end
    end else begin
      put_we = 1'b1;
      if (cur_col == ttc_pkg::LAST_COL) begin
        cur_col_next = '0;
        row_adv = 1'b1;
      end else begin
        cur_col_next = cur_col + 1'b1;
      end
    end
    if (row_adv) begin
      if (cur_row == ttc_pkg::LAST_ROW) begin
        put_scroll = 1'b1;
        // new bottom row lives where the old top row was
        clr_base_next = ttc_pkg::cell_addr(origin_row, '0);
        origin_row_next = ttc_pkg::phys_row(origin_row, ttc_pkg::ROW_W'(1));
      end else begin
        cur_row_next = cur_row + 1'b1;
      end
    end
  end

  assign put_done = accept && !is_read && !put_scroll;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ttc_pkg::ST_INIT: begin
        if (init_cnt == ttc_pkg::LAST_ADDR) state_next = ttc_pkg::ST_IDLE;
      end
      ttc_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_read)         state_next = ttc_pkg::ST_READ;
          else if (put_scroll) state_next = ttc_pkg::ST_CLEAR;
        end
      end
      ttc_pkg::ST_READ: state_next = ttc_pkg::ST_IDLE;
      ttc_pkg::ST_CLEAR: begin
        if (clear_count == ttc_pkg::LAST_COL) state_next = ttc_pkg::ST_IDLE;
      end
      default: state_next = ttc_pkg::ST_INIT;
    endcase
  end

  // memory port control and result load
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ttc_pkg::cell_addr(ttc_pkg::phys_row(origin_row, put_row), put_col);
    mem_wdata = {text_color, put_ch};
    mem_raddr = ttc_pkg::cell_addr(ttc_pkg::phys_row(origin_row, req.read_row), req.read_col);
    out_load  = 1'b0;
    o_char_next  = '0;
    o_color_next = '0;
    unique case (state)
      ttc_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_cnt;
        mem_wdata = ttc_pkg::RESET_CELL;
      end
      ttc_pkg::ST_IDLE: begin
        mem_we   = accept && !is_read && put_we;
        out_load = put_done;
      end
      ttc_pkg::ST_READ: begin
        out_load = 1'b1;
        if (rd_ok) begin
          o_char_next  = mem_rdata[7:0];
          o_color_next = mem_rdata[15:8];
        end
      end
      ttc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_base + ttc_pkg::ADDR_W'(clear_count);
        mem_wdata = {text_color, ttc_pkg::CH_SPACE};
        out_load  = (clear_count == ttc_pkg::LAST_COL);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ttc_pkg::ST_INIT;
      init_cnt    <= '0;
      clear_count <= '0;
      origin_row  <= '0;
      cur_row     <= '0;
      cur_col     <= '0;
      text_color  <= ttc_pkg::COLOR_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ttc_pkg::ST_INIT) init_cnt <= init_cnt + 1'b1;
      if (state == ttc_pkg::ST_CLEAR) begin
        clear_count <= (clear_count == ttc_pkg::LAST_COL) ? '0 : clear_count + 1'b1;
      end
      if (color_we) text_color <= color_wdata;
      if (accept && !is_read) begin
        cur_row    <= cur_row_next;
        cur_col    <= cur_col_next;
        origin_row <= origin_row_next;
      end
      if (out_load)       out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok    <= (int'(req.read_row) < ttc_pkg::ROWS) && (int'(req.read_col) < ttc_pkg::COLUMNS);
      clr_base <= clr_base_next;
    end
    if (out_load) begin
      o_char  <= o_char_next;
      o_color <= o_color_next;
      o_row   <= (state == ttc_pkg::ST_IDLE) ? cur_row_next : cur_row;
      o_col   <= (state == ttc_pkg::ST_IDLE) ? cur_col_next : cur_col;
      o_scr   <= (state == ttc_pkg::ST_CLEAR);
    end
  end

  assign res.valid      = out_valid;
  assign res.cell_char  = o_char;
  assign res.cell_color = o_color;
  assign res.cursor_row = o_row;
  assign res.cursor_col = o_col;
  assign res.scrolled   = o_scr;

  `TTC_ASSERT_NEXT(a_scroll_clears, accept && !is_read && put_scroll, state == ttc_pkg::ST_CLEAR, "scroll without row clear")
  `TTC_ASSERT_NOW(a_clear_writes, state == ttc_pkg::ST_CLEAR, mem_we, "row clear skipped a cell")
  `TTC_ASSERT_NOW(a_read_slot_free, state == ttc_pkg::ST_READ, !out_valid, "read data with result register busy")
  `TTC_ASSERT_NOW(a_cursor_range, 1'b1, cur_row <= ttc_pkg::LAST_ROW && cur_col <= ttc_pkg::LAST_COL, "cursor off screen")

endmodule

### verif/ttc_tb_pkg.sv
// Screen mirror and result checker for the text terminal engine testbench.
// Depends on ttc_pkg for geometry, widths and character codes.
package ttc_tb_pkg;
  import ttc_pkg::*;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic [7:0]       ch;
    logic [7:0]       color;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             scrolled;
  } cell_view_t;

  class screen_mirror;
    logic [15:0]  cells [DEPTH];
    int unsigned  origin;
    int unsigned  crow;
    int unsigned  ccol;
    logic [7:0]   color;
    cell_view_t   due_views [$];
    int unsigned  errors;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        cells[i] = RESET_CELL;
      end
      origin = 0;
      crow   = 0;
      ccol   = 0;
      color  = COLOR_RESET;
      errors = 0;
    endfunction

    function int unsigned slot(int unsigned lrow, int unsigned col);
      return ((origin + lrow) % ROWS) * COLUMNS + col;
    endfunction

    function void store(int unsigned lrow, int unsigned col, logic [7:0] ch);
      cells[slot(lrow, col)] = {color, ch};
    endfunction

    // cursor moves down a row; leaving the bottom row moves the ring origin and blanks the new bottom row
    function logic next_line();
      crow++;
      if (crow < ROWS) begin
        return 1'b0;
      end
      crow   = ROWS - 1;
      origin = (origin + 1) % ROWS;
      for (int c = 0; c < COLUMNS; c++) begin
        store(ROWS - 1, c, CH_SPACE);
      end
      return 1'b1;
    endfunction

    function void take_item(logic mode, logic [7:0] ch,
                            logic [ROW_W-1:0] rrow, logic [COL_W-1:0] rcol);
      cell_view_t  v;
      logic [15:0] c;
      v = '0;
      if (mode == MODE_READ) begin
        if (rrow < ROWS && rcol < COLUMNS) begin
          c       = cells[slot(rrow, rcol)];
          v.ch    = c[7:0];
          v.color = c[15:8];
        end
      end else if (ch == CH_NEWLINE) begin
        ccol       = 0;
        v.scrolled = next_line();
      end else if (ch == CH_BACKSPACE) begin
        if (ccol != 0 || crow != 0) begin
          if (ccol != 0) begin
            ccol--;
          end else begin
            ccol = COLUMNS - 1;
            crow--;
          end
          store(crow, ccol, CH_SPACE);
        end
      end else begin
        store(crow, ccol, ch);
        ccol++;
        if (ccol >= COLUMNS) begin
          ccol       = 0;
          v.scrolled = next_line();
        end
      end
      v.row = ROW_W'(crow);
      v.col = COL_W'(ccol);
      due_views.push_back(v);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%0t ns: %s", $time, msg);
      end
    endfunction

    function void match_view(cell_view_t got);
      cell_view_t want;
      if (due_views.size() == 0) begin
        note_error($sformatf("result with none outstanding: ch=%02h color=%02h row=%0d col=%0d scr=%0b",
                             got.ch, got.color, got.row, got.col, got.scrolled));
        return;
      end
      want = due_views.pop_front();
      if (got.ch !== want.ch || got.color !== want.color || got.row !== want.row ||
          got.col !== want.col || got.scrolled !== want.scrolled) begin
        note_error($sformatf({"mismatch: exp ch=%02h color=%02h row=%0d col=%0d scr=%0b",
                              " got ch=%02h color=%02h row=%0d col=%0d scr=%0b"},
                             want.ch, want.color, want.row, want.col, want.scrolled,
                             got.ch, got.color, got.row, got.col, got.scrolled));
      end
    endfunction
  endclass

endpackage

### verif/tb_text_terminal_cursor_engine.sv
// Testbench top for text_terminal_cursor_engine: directed and random put/read items.
// Depends on ttc_pkg, ttc_in_if, ttc_out_if, ttc_tb_pkg and the engine RTL.
module tb_text_terminal_cursor_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ttc_pkg::*;
  import ttc_tb_pkg::*;

  logic         clk;
  logic         rst;
  logic         color_we;
  logic [7:0]   color_wdata;
  int unsigned  idle_pct = 27;
  screen_mirror mirror = new();

  ttc_in_if  req();
  ttc_out_if res();

  text_terminal_cursor_engine i_dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .res         (res),
    .color_we    (color_we),
    .color_wdata (color_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) begin
        mirror.match_view({res.cell_char, res.cell_color, res.cursor_row,
                           res.cursor_col, res.scrolled});
      end
      res.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_item(input logic mode, input logic [7:0] ch,
                           input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.mode      <= mode;
    req.char_code <= ch;
    req.read_row  <= rrow;
    req.read_col  <= rcol;
    do @(posedge clk); while (!req.ready);
    mirror.take_item(mode, ch, rrow, rcol);
  endtask

  task automatic put(input logic [7:0] ch);
    send_item(MODE_PUT, ch, ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
  endtask

  task automatic peek(input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol);
    send_item(MODE_READ, 8'($urandom_range(255)), rrow, rcol);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    while (mirror.due_views.size() != 0) @(posedge clk);
  endtask

  // register only changes with nothing in flight, including a row clear
  task automatic write_color(input logic [7:0] hue);
    settle();
    repeat (100) @(posedge clk);
    color_we    <= 1'b1;
    color_wdata <= hue;
    @(posedge clk);
    color_we    <= 1'b0;
    mirror.color = hue;
  endtask

  task automatic send_random(inout int unsigned sent);
    int unsigned      pick;
    logic [ROW_W-1:0] rr;
    logic [COL_W-1:0] rc;
    pick = $urandom_range(99);
    if (pick < 2) begin
      repeat ($urandom_range(30, 20)) begin
        put(CH_NEWLINE);
        sent++;
      end
    end else if (pick < 5) begin
      repeat ($urandom_range(COLUMNS + 10, COLUMNS - 10)) begin
        put(8'($urandom_range(8'h7E, 8'h20)));
        sent++;
      end
    end else if (pick < 30) begin
      rr = ROW_W'($urandom_range(ROWS - 1));
      rc = COL_W'($urandom_range(COLUMNS - 1));
      if ($urandom_range(9) == 0) begin
        rr = ROW_W'($urandom_range(31));
        rc = COL_W'($urandom_range(127));
      end else if ($urandom_range(2) == 0) begin
        rr = ROW_W'(mirror.crow);
      end
      peek(rr, rc);
      sent++;
    end else if (pick < 42) begin
      put(CH_NEWLINE);
      sent++;
    end else if (pick < 54) begin
      put(CH_BACKSPACE);
      sent++;
    end else begin
      put(8'($urandom_range(255)));
      sent++;
    end
  endtask

  initial begin
    logic [7:0]  hues [6];
    int unsigned sent;
    hues = '{8'h00, 8'hFF, 8'h5A, 8'h0F, 8'hF0, 8'h80};
    hues[5] = 8'($urandom_range(255));

    rst           = 1'b1;
    color_we      = 1'b0;
    color_wdata   = 8'h00;
    req.valid     = 1'b0;
    req.mode      = MODE_PUT;
    req.char_code = 8'h00;
    req.read_row  = '0;
    req.read_col  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset fill, out-of-range reads and directed put, backspace and newline items
    peek(ROW_W'(0), COL_W'(0));
    peek(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
    peek(ROW_W'(31), COL_W'(127));
    peek(ROW_W'(ROWS), COL_W'(0));
    peek(ROW_W'(0), COL_W'(COLUMNS));
    put(CH_BACKSPACE);
    put(8'h41);
    put(8'hFF);
    put(8'h00);
    put(CH_BACKSPACE);
    peek(ROW_W'(0), COL_W'(2));
    put(CH_NEWLINE);
    put(CH_BACKSPACE);
    put(8'h7E);
    peek(ROW_W'(0), COL_W'(COLUMNS - 1));
    put(8'h09);
    put(8'h0B);
    put(8'h07);
    peek(ROW_W'(1), COL_W'(0));
    peek(ROW_W'(0), COL_W'(0));

    for (int p = 0; p < 6; p++) begin
      write_color(hues[p]);
      idle_pct = (p == 2) ? 0 : 27;
      sent = 0;
      while (sent < 250) begin
        send_random(sent);
      end
    end

    settle();
    repeat (100) @(posedge clk);
    if (mirror.due_views.size() != 0) begin
      mirror.note_error($sformatf("%0d results never arrived", mirror.due_views.size()));
    end
    if (mirror.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
